>>> rtl/core/phpd_pkg.sv
`default_nettype none

package phpd_pkg;

    localparam int IN_W      = 160;
    localparam int OUT_W     = 128;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 2;
    localparam int STAGES    = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_CHIP_LAYOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_GDC     = 1'b1;

    typedef enum logic [1:0] {
        LAYOUT_SINGLE = 2'd0,
        LAYOUT_DOUBLE = 2'd1,
        LAYOUT_TRIPLE = 2'd2,
        LAYOUT_NONE   = 2'd3
    } t_layout;

    localparam logic [19:0] TOF_PERIOD    = 20'd666667;
    localparam logic [48:0] TOF_BOUND     = 49'd666800;
    localparam logic [49:0] TOF_OFFSET    = 50'd134;
    localparam logic [47:0] ADJ_LIMIT     = 48'd40000000;
    localparam logic [47:0] SIMPLE_MARGIN = 48'h40_0000;
    localparam logic [49:0] GLOBAL_STEP   = 50'h4000_0000;

    // Residues used to fold a 50-bit value modulo the period, and the reciprocal of the period.
    localparam logic [19:0] K20  = 20'((64'd1 << 20) % 64'd666667);
    localparam logic [19:0] K40  = 20'((64'd1 << 40) % 64'd666667);
    localparam logic [19:0] KNEG = 20'(64'hFFFC_0000_0000_0000 % 64'd666667);
    localparam logic [21:0] RECIP = 22'((64'd1 << 41) / 64'd666667);

    typedef struct packed {
        logic [9:0]  x;
        logic [9:0]  y;
        logic [9:0]  tot;
        logic [13:0] toa;
        logic [3:0]  ftoa;
    } t_hit;

    typedef struct packed {
        t_hit        hit;
        logic [47:0] gt;
        logic        flight_valid;
        logic        use_mod;
        logic [30:0] direct;
    } t_res;

endpackage

`default_nettype wire

>>> rtl/core/pixel_hit_packet_decoder_core.sv
`default_nettype none

// Pixel hit packet decoder. One packet is accepted per clock unless the output stalls with every
// stage full; its result leaves on the master side after the ten register stages, of which
// the modulo reduction of the time of flight by the 666667 period takes the last six (two
// folding multiplies, a sum, a reciprocal multiply, a quotient multiply, a remainder
// subtraction and a final correction).
// Each stage holds its request while the next one is full and stalled, so an empty stage lets a new
// packet in even while the output waits; chip_layout and use_gdc must only be written
// while the pipeline is empty.
module pixel_hit_packet_decoder_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_wen,
    input  wire [phpd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [phpd_pkg::CFG_DAT_W-1:0]    i_cfg_wdata,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // packet_low, packet_high, trigger time, global coarse time
    input  wire [phpd_pkg::IN_W-1:0]         s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // pixel_x, pixel_y, time_over_threshold, time_of_arrival, fine_toa,
    // global_time, flight_time, zero pad
    output logic [phpd_pkg::OUT_W-1:0]       m_axis_tdata,
    // flight_time_valid
    output logic                             m_axis_tuser
);
    import phpd_pkg::*;

    t_layout      r_layout;
    logic         r_use_gdc;
    logic [STAGES:1] r_v;
    logic [STAGES:1] w_rdy;

    t_hit         r_hit [1:3];
    logic         r_gdc_mode [1:3];
    logic [47:0]  r_s1_g0;
    logic [30:0]  r_s1_sg;
    logic [47:0]  r_s1_tdc;
    logic [47:0]  r_s1_gdc;
    logic [49:0]  r_s2_g1;
    logic [47:0]  r_s2_tdc;
    logic [47:0]  r_s3_gt;
    logic [49:0]  r_s3_t;

    t_res         r_res [4:STAGES];
    logic [49:0]  r_s4_w;
    logic [19:0]  r_s4_cadd;
    logic [29:0]  r_s5_pa;
    logic [39:0]  r_s5_pb;
    logic [19:0]  r_s5_c;
    logic [19:0]  r_s5_cadd;
    logic [40:0]  r_s6_s;
    logic [43:0]  r_s7_qp;
    logic [20:0]  r_s7_sl;
    logic [20:0]  r_s8_qpl;
    logic [20:0]  r_s8_sl;
    logic [20:0]  r_s9_r0;
    logic [30:0]  r_ft;

    logic [31:0]  n_lo;
    logic [31:0]  n_hi;
    logic [47:0]  n_tdc;
    logic [47:0]  n_gdc;
    logic [15:0]  n_addr;
    logic [9:0]   n_bx;
    logic [9:0]   n_by;
    logic [29:0]  n_spider;
    logic [17:0]  n_msb;
    t_hit         n_s1_hit;
    logic [47:0]  n_s1_g0;
    logic [30:0]  n_s1_sg;
    logic [48:0]  n_diff;
    logic         n_adj;
    logic [49:0]  n_s2_g1;
    logic         n_neg;
    logic         n_big;
    logic         n_gm;
    t_res         n_s4_res;
    logic [41:0]  n_qfull;
    logic [20:0]  n_r1;
    logic [30:0]  n_ft;

    always_comb begin
        w_rdy[STAGES] = !r_v[STAGES] || m_axis_tready;
        for (int k = STAGES - 1; k >= 1; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign s_axis_tready = w_rdy[1];

    always_comb begin
        n_lo     = s_axis_tdata[31:0];
        n_hi     = s_axis_tdata[63:32];
        n_tdc    = s_axis_tdata[111:64];
        n_gdc    = s_axis_tdata[159:112];
        n_addr   = n_hi[27:12];
        n_bx     = {2'b00, n_addr[15:9], n_addr[2]};
        n_by     = {2'b00, n_addr[8:3], n_addr[1:0]};
        n_s1_hit.ftoa = n_lo[19:16];
        n_s1_hit.tot  = n_lo[29:20];
        n_s1_hit.toa  = {n_hi[11:0], n_lo[31:30]};
        n_spider = {n_lo[15:0], n_s1_hit.toa};
        case (r_layout)
            LAYOUT_SINGLE: begin
                n_s1_hit.x = n_bx + 10'd260;
                n_s1_hit.y = n_by;
            end
            LAYOUT_DOUBLE: begin
                n_s1_hit.x = 10'd515 - n_bx;
                n_s1_hit.y = 10'd515 - n_by;
            end
            LAYOUT_TRIPLE: begin
                n_s1_hit.x = 10'd255 - n_bx;
                n_s1_hit.y = 10'd515 - n_by;
            end
            default: begin
                n_s1_hit.x = n_bx;
                n_s1_hit.y = n_by;
            end
        endcase
        n_msb   = n_gdc[47:30] + 18'(n_spider < n_gdc[29:0]);
        n_s1_g0 = {n_msb, n_spider};
        n_s1_sg = {(n_tdc > (48'(n_spider) + SIMPLE_MARGIN)), n_spider};
    end

    always_comb begin
        n_diff = {1'b0, r_s1_g0} - {1'b0, r_s1_gdc};
        n_adj  = n_diff[48] || (n_diff[47:0] >= ADJ_LIMIT);
        if (!r_gdc_mode[1]) begin
            n_s2_g1 = 50'(r_s1_sg);
        end else if (n_adj) begin
            n_s2_g1 = {2'b00, r_s1_g0} - GLOBAL_STEP;
        end else begin
            n_s2_g1 = {2'b00, r_s1_g0};
        end
    end

    always_comb begin
        n_gm  = r_gdc_mode[3];
        n_neg = r_s3_t[49];
        n_big = !n_neg && (r_s3_t[48:0] > TOF_BOUND);
        n_s4_res.hit          = r_hit[3];
        n_s4_res.gt           = r_s3_gt;
        n_s4_res.flight_valid = n_gm || !n_neg;
        n_s4_res.use_mod      = n_gm && (n_neg || n_big);
        n_s4_res.direct       = (!n_gm && n_neg) ? 31'd0 : r_s3_t[30:0];
    end

    always_comb begin
        n_qfull = 42'(r_s7_qp[43:22]) * 42'(TOF_PERIOD);
        if (r_s9_r0 >= 21'({TOF_PERIOD, 1'b0})) begin
            n_r1 = r_s9_r0 - 21'({TOF_PERIOD, 1'b0});
        end else if (r_s9_r0 >= 21'(TOF_PERIOD)) begin
            n_r1 = r_s9_r0 - 21'(TOF_PERIOD);
        end else begin
            n_r1 = r_s9_r0;
        end
        n_ft = r_res[9].use_mod ? (31'(n_r1) + 31'(TOF_OFFSET)) : r_res[9].direct;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v       <= '0;
            r_layout  <= LAYOUT_SINGLE;
            r_use_gdc <= 1'b1;
        end else begin
            if (i_cfg_wen) begin
                case (i_cfg_idx)
                    CFG_CHIP_LAYOUT: r_layout  <= t_layout'(i_cfg_wdata[1:0]);
                    CFG_USE_GDC:     r_use_gdc <= i_cfg_wdata[0];
                    default:         r_use_gdc <= r_use_gdc;
                endcase
            end
            if (w_rdy[1]) begin
                r_v[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_hit[1]      <= n_s1_hit;
            r_gdc_mode[1] <= r_use_gdc;
            r_s1_g0       <= n_s1_g0;
            r_s1_sg       <= n_s1_sg;
            r_s1_tdc      <= n_tdc;
            r_s1_gdc      <= n_gdc;
        end
        if (w_rdy[2]) begin
            r_hit[2]      <= r_hit[1];
            r_gdc_mode[2] <= r_gdc_mode[1];
            r_s2_g1       <= n_s2_g1;
            r_s2_tdc      <= r_s1_tdc;
        end
        if (w_rdy[3]) begin
            r_hit[3]      <= r_hit[2];
            r_gdc_mode[3] <= r_gdc_mode[2];
            r_s3_gt       <= r_s2_g1[47:0];
            r_s3_t        <= r_s2_g1 - {2'b00, r_s2_tdc};
        end
        if (w_rdy[4]) begin
            r_res[4]  <= n_s4_res;
            r_s4_w    <= r_s3_t - TOF_OFFSET;
            r_s4_cadd <= (n_gm && n_neg) ? KNEG : 20'd0;
        end
        if (w_rdy[5]) begin
            r_res[5]  <= r_res[4];
            r_s5_pa   <= 30'(r_s4_w[49:40]) * 30'(K40);
            r_s5_pb   <= 40'(r_s4_w[39:20]) * 40'(K20);
            r_s5_c    <= r_s4_w[19:0];
            r_s5_cadd <= r_s4_cadd;
        end
        if (w_rdy[6]) begin
            r_res[6] <= r_res[5];
            r_s6_s   <= 41'(r_s5_pa) + 41'(r_s5_pb) + 41'(r_s5_c) + 41'(r_s5_cadd);
        end
        if (w_rdy[7]) begin
            r_res[7] <= r_res[6];
            r_s7_qp  <= 44'(r_s6_s[40:19]) * 44'(RECIP);
            r_s7_sl  <= r_s6_s[20:0];
        end
        if (w_rdy[8]) begin
            r_res[8] <= r_res[7];
            r_s8_qpl <= n_qfull[20:0];
            r_s8_sl  <= r_s7_sl;
        end
        if (w_rdy[9]) begin
            r_res[9] <= r_res[8];
            r_s9_r0  <= r_s8_sl - r_s8_qpl;
        end
        if (w_rdy[10]) begin
            r_res[10] <= r_res[9];
            r_ft      <= n_ft;
        end
    end

    assign m_axis_tvalid = r_v[STAGES];
    assign m_axis_tuser  = r_res[STAGES].flight_valid;
    assign m_axis_tdata  = {1'b0, r_ft, r_res[STAGES].gt, r_res[STAGES].hit.ftoa,
                            r_res[STAGES].hit.toa, r_res[STAGES].hit.tot,
                            r_res[STAGES].hit.y, r_res[STAGES].hit.x};

`ifndef NO_ASSERTIONS
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[9] && r_res[9].use_mod |-> r_s9_r0 < 21'(3 * 666667))
        else $error("reciprocal quotient estimate is off by more than two");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[STAGES] && !r_res[STAGES].flight_valid |-> r_ft == 31'd0)
        else $error("invalid flight time is not zero");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[STAGES] && r_res[STAGES].use_mod |-> r_ft <= 31'd666800)
        else $error("reduced flight time exceeds the loop bound");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[5] && !w_rdy[5] |=> r_v[5] && $stable(r_s5_pb) && $stable(r_res[5]))
        else $error("stalled stage changed its request");
`endif

endmodule

`default_nettype wire

>>> bench/tb_pixel_hit_packet_decoder_core.sv
`default_nettype none

module tb_pixel_hit_packet_decoder_core;
    import phpd_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 14;
    localparam int HOLD_CYCLES  = 150;

    localparam logic [63:0] GLOBAL_MASK  = 64'hFFFF_C000_0000;
    localparam logic [63:0] EXTEND_LIMIT = 64'd40_000_000;
    localparam logic [63:0] EPOCH_STEP   = 64'h4000_0000;
    localparam logic [63:0] FLIGHT_BOUND = 64'd666_800;
    localparam logic [63:0] FLIGHT_WRAP  = 64'd666_667;
    localparam logic [63:0] FLIGHT_BASE  = 64'd134;
    localparam logic [63:0] TDC_MARGIN   = 64'h40_0000;

    typedef struct packed {
        logic [9:0]  x;
        logic [9:0]  y;
        logic [9:0]  tot;
        logic [13:0] toa;
        logic [3:0]  ftoa;
        logic [47:0] gtime;
        logic [30:0] flight;
        logic        flight_ok;
    } t_hit_fields;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_CHIP_LAYOUT;
    logic [CFG_DAT_W-1:0] i_cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    wire                  s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata = '0;
    wire                  m_axis_tvalid;
    logic                 m_axis_tready = 1'b1;
    wire  [OUT_W-1:0]     m_axis_tdata;
    wire                  m_axis_tuser;

    t_layout     layout_now = LAYOUT_SINGLE;
    logic        gdc_mode_now = 1'b1;
    t_hit_fields pending_hits[$];
    int          errors = 0;
    int          hits_sent = 0;
    int          hits_checked = 0;
    int          no_flight_count = 0;
    int          idle_cycles = 0;
    logic        src_idle_en = 1'b1;
    logic        sink_idle_en = 1'b1;
    logic        sink_hold = 1'b0;

    pixel_hit_packet_decoder_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_hit_fields decode_hit(input logic [IN_W-1:0] req);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] tdc;
        logic [63:0] gdc;
        logic [63:0] spider;
        logic [63:0] addr;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] epoch;
        logic [63:0] gtime;
        logic [63:0] flight;
        t_hit_fields r;
        lo  = 64'(req[31:0]);
        hi  = 64'(req[63:32]);
        tdc = 64'(req[111:64]);
        gdc = 64'(req[159:112]);
        r.ftoa = lo[19:16];
        r.tot  = lo[29:20];
        r.toa  = {hi[11:0], lo[31:30]};
        spider = 64'({lo[15:0], r.toa});
        addr = 64'(hi[27:12]);
        x = 64'(addr[15:9]) * 2 + 64'(addr[2]);
        y = 64'(addr[8:3]) * 4 + 64'(addr[1:0]);
        case (layout_now)
            LAYOUT_SINGLE: begin
                x = x + 64'd260;
            end
            LAYOUT_DOUBLE: begin
                x = 64'd515 - x;
                y = 64'd515 - y;
            end
            LAYOUT_TRIPLE: begin
                x = 64'd255 - x;
                y = 64'd515 - y;
            end
            default: begin
            end
        endcase
        r.flight_ok = 1'b1;
        if (gdc_mode_now) begin
            epoch = 64'(gdc[47:30]);
            if (spider < 64'(gdc[29:0])) begin
                epoch = epoch + 1;
            end
            gtime = ((epoch << 30) & GLOBAL_MASK) | spider;
            if (gtime - gdc >= EXTEND_LIMIT) begin
                gtime = gtime - EPOCH_STEP;
            end
            flight = gtime - tdc;
            if (flight > FLIGHT_BOUND) begin
                flight = FLIGHT_BASE + (flight - FLIGHT_BASE) % FLIGHT_WRAP;
            end
        end else begin
            gtime = spider;
            if (tdc > gtime + TDC_MARGIN) begin
                gtime = gtime | EPOCH_STEP;
            end
            if (gtime >= tdc) begin
                flight = gtime - tdc;
            end else begin
                flight = 64'd0;
                r.flight_ok = 1'b0;
            end
        end
        r.x      = x[9:0];
        r.y      = y[9:0];
        r.gtime  = gtime[47:0];
        r.flight = flight[30:0];
        return r;
    endfunction

    function automatic logic [63:0] make_packet(input logic [29:0] spider,
                                                input logic [15:0] addr,
                                                input logic [9:0] tot,
                                                input logic [3:0] ftoa,
                                                input logic [3:0] ptype);
        return {ptype, addr, spider[13:2], spider[1:0], tot, ftoa, spider[29:14]};
    endfunction

    task automatic flag_error(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            flag_error($sformatf("%s got 0x%0h expected 0x%0h (hit %0d)",
                                 name, got, want, hits_checked));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            pending_hits.push_back(decode_hit(s_axis_tdata));
            hits_sent++;
        end
    end

    always @(posedge i_clk) begin
        t_hit_fields want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_hits.size() == 0) begin
                flag_error($sformatf("result 0x%0h with no request outstanding",
                                     m_axis_tdata));
            end else begin
                want = pending_hits.pop_front();
                check_field("pixel_x", 64'(m_axis_tdata[9:0]), 64'(want.x));
                check_field("pixel_y", 64'(m_axis_tdata[19:10]), 64'(want.y));
                check_field("time_over_threshold", 64'(m_axis_tdata[29:20]), 64'(want.tot));
                check_field("time_of_arrival", 64'(m_axis_tdata[43:30]), 64'(want.toa));
                check_field("fine_toa", 64'(m_axis_tdata[47:44]), 64'(want.ftoa));
                check_field("global_time", 64'(m_axis_tdata[95:48]), 64'(want.gtime));
                check_field("flight_time", 64'(m_axis_tdata[126:96]), 64'(want.flight));
                check_field("flight_time_valid", 64'(m_axis_tuser), 64'(want.flight_ok));
                if (!want.flight_ok) begin
                    no_flight_count++;
                end
                hits_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
            $display("tb_pixel_hit_packet_decoder_core NOT OK");
            $finish;
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (sink_hold) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                m_axis_tready <= 1'b1;
                sink_hold = 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_hit(input logic [63:0] packet, input logic [47:0] tdc,
                            input logic [47:0] gdc);
        if (src_idle_en && $urandom_range(0, 6) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {gdc, tdc, packet};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic settle_pipeline();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        i_cfg_wen   <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_CHIP_LAYOUT) begin
            layout_now = t_layout'(val);
        end else begin
            gdc_mode_now = val[0];
        end
    endtask

    task automatic send_random_hit();
        logic [29:0] spider;
        logic [47:0] tdc;
        logic [47:0] gdc;
        logic [63:0] packet;
        gdc    = 48'({$urandom, $urandom});
        tdc    = 48'({$urandom, $urandom});
        packet = {$urandom, $urandom};
        if ($urandom_range(0, 3) != 0) begin
            if (gdc_mode_now) begin
                spider = gdc[29:0] + 30'($urandom_range(0, 60_000_000)) - 30'd10_000_000;
                tdc = gdc - 48'($urandom_range(0, 1_400_000))
                      + 48'($urandom_range(0, 200_000));
            end else begin
                spider = 30'($urandom);
                tdc = 48'(spider) + 48'($urandom_range(0, 32'h60_0000)) - 48'h10_0000;
            end
            packet = make_packet(spider, 16'($urandom), 10'($urandom), 4'($urandom),
                                 4'($urandom));
        end
        send_hit(packet, tdc, gdc);
    endtask

    task automatic test_field_extremes();
        send_hit(64'd0, 48'd0, 48'd0);
        send_hit('1, '1, '1);
        send_hit(make_packet(30'd0, 16'hFFFF, 10'h3FF, 4'hF, 4'hB), 48'd0, 48'd0);
        send_hit(make_packet(30'h3FFF_FFFF, 16'h0000, 10'h000, 4'h0, 4'h0),
                 48'h3FFF_FFFF, 48'h3FFF_FFFF);
    endtask

    task automatic test_gdc_corner_cases();
        // The epoch counter overflows its 18 bits here and the result wraps below zero.
        send_hit(make_packet(30'h100, 16'h1234, 10'd5, 4'd3, 4'hB), 48'd0, 48'hFFFF_FFFF_0000);
        send_hit(make_packet(30'd50_000_000, 16'h0201, 10'd9, 4'd1, 4'hB), 48'd0, 48'd5);
        send_hit(make_packet(30'd667_800, 16'h0042, 10'd1, 4'd2, 4'hB), 48'd1000, 48'd1000);
        send_hit(make_packet(30'd667_801, 16'h0042, 10'd1, 4'd2, 4'hB), 48'd1000, 48'd1000);
        send_hit(make_packet(30'd1000, 16'h0099, 10'd7, 4'd4, 4'hB), 48'd2000, 48'd1000);
    endtask

    task automatic test_layouts();
        t_layout layouts[3];
        layouts = '{LAYOUT_DOUBLE, LAYOUT_TRIPLE, LAYOUT_NONE};
        foreach (layouts[i]) begin
            settle_pipeline();
            write_reg(CFG_CHIP_LAYOUT, layouts[i]);
            send_hit(make_packet(30'd12345, 16'h0000, 10'd3, 4'd1, 4'hB), 48'd100, 48'd200);
            send_hit(make_packet(30'd12345, 16'hFFFF, 10'd3, 4'd1, 4'hB), 48'd100, 48'd200);
        end
    endtask

    task automatic test_simple_timing();
        settle_pipeline();
        write_reg(CFG_CHIP_LAYOUT, LAYOUT_SINGLE);
        write_reg(CFG_USE_GDC, 2'd0);
        send_hit(make_packet(30'd100, 16'h0101, 10'd2, 4'd6, 4'hB), 48'd200, 48'd0);
        send_hit(make_packet(30'd10, 16'h0101, 10'd2, 4'd6, 4'hB), 48'h50_0000, 48'd0);
        send_hit(make_packet(30'd12345, 16'h0101, 10'd2, 4'd6, 4'hB), 48'd12345, 48'd0);
        send_hit(make_packet(30'd77, 16'h0101, 10'd2, 4'd6, 4'hB), '1, '1);
    endtask

    task automatic test_random_mix();
        t_layout layouts[8];
        logic    modes[8];
        layouts = '{LAYOUT_SINGLE, LAYOUT_DOUBLE, LAYOUT_TRIPLE, LAYOUT_NONE,
                    LAYOUT_NONE, LAYOUT_SINGLE, LAYOUT_DOUBLE, LAYOUT_TRIPLE};
        modes   = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        foreach (layouts[i]) begin
            settle_pipeline();
            write_reg(CFG_CHIP_LAYOUT, layouts[i]);
            write_reg(CFG_USE_GDC, 2'(modes[i]));
            repeat (100) send_random_hit();
        end
    endtask

    task automatic test_sink_hold();
        settle_pipeline();
        write_reg(CFG_CHIP_LAYOUT, LAYOUT_TRIPLE);
        write_reg(CFG_USE_GDC, 2'd1);
        src_idle_en = 1'b0;
        sink_hold = 1'b1;
        repeat (50) send_random_hit();
        src_idle_en = 1'b1;
    endtask

    task automatic test_full_rate();
        settle_pipeline();
        write_reg(CFG_CHIP_LAYOUT, LAYOUT_SINGLE);
        write_reg(CFG_USE_GDC, 2'd0);
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        repeat (30) send_random_hit();
        settle_pipeline();
        write_reg(CFG_USE_GDC, 2'd1);
        repeat (30) send_random_hit();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_field_extremes();
        test_gdc_corner_cases();
        test_layouts();
        test_simple_timing();
        test_random_mix();
        test_sink_hold();
        test_full_rate();
        settle_pipeline();
        $display("Checked %0d of %0d decoded hits over all four layouts in GDC and simple mode,",
                 hits_checked, hits_sent);
        $display("with %0d hits lacking a flight time and one long output hold-off.",
                 no_flight_count);
        if (errors == 0) begin
            $display("tb_pixel_hit_packet_decoder_core OK");
        end else begin
            $display("tb_pixel_hit_packet_decoder_core NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/core/phpd_pkg.sv
rtl/core/pixel_hit_packet_decoder_core.sv
bench/tb_pixel_hit_packet_decoder_core.sv
